### src/hms_pkg.sv
// Shared types, codes and lookup functions for the hh:mm:ss clock block.
// No dependencies; imported by every module of the block.
package hms_pkg;

	localparam logic [5:0] SEC_WRAP      = 6'd60;
	localparam logic [5:0] MIN_WRAP      = 6'd60;
	localparam logic [4:0] HOUR_WRAP     = 5'd24;
	localparam logic [4:0] HOUR_MAX      = 5'd23;
	localparam logic [5:0] MIN_MAX       = 6'd59;
	localparam logic [4:0] HOUR_RESET    = 5'd12;
	localparam logic [3:0] HOLD_RESET    = 4'd3;
	localparam logic [2:0] LAST_DIGIT    = 3'd5;
	localparam logic [7:0] SEG_BLANK     = 8'hff;
	localparam logic [7:0] TENS_RECIP    = 8'd205;
	localparam int         TENS_SHIFT    = 11;

	typedef enum logic [1:0] {
		KIND_SEC_TICK   = 2'd0,
		KIND_BLINK_TICK = 2'd1,
		KIND_BUTTON     = 2'd2,
		KIND_SCAN       = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		MODE_RUN      = 3'b001,
		MODE_SET_MIN  = 3'b010,
		MODE_SET_HOUR = 3'b100
	} mode_t;

	localparam logic [1:0] MODE_CODE_RUN  = 2'd0;
	localparam logic [1:0] MODE_CODE_MIN  = 2'd1;
	localparam logic [1:0] MODE_CODE_HOUR = 2'd2;

	typedef struct packed {
		kind_t kind;
		logic  set_button;
		logic  up_button;
		logic  down_button;
	} item_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] min;
		logic [5:0] sec;
		mode_t      mode;
		logic       blink;
		logic [2:0] scan;
	} clk_state_t;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		unique case (m)
			MODE_RUN:      c = MODE_CODE_RUN;
			MODE_SET_MIN:  c = MODE_CODE_MIN;
			MODE_SET_HOUR: c = MODE_CODE_HOUR;
			default:       c = MODE_CODE_RUN;
		endcase
		return c;
	endfunction

	// common-anode patterns, bit 7 is the dot
	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0:    s = 8'hc0;
			4'd1:    s = 8'hf9;
			4'd2:    s = 8'ha4;
			4'd3:    s = 8'hb0;
			4'd4:    s = 8'h99;
			4'd5:    s = 8'h92;
			4'd6:    s = 8'h82;
			4'd7:    s = 8'hf8;
			4'd8:    s = 8'h80;
			4'd9:    s = 8'h90;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

### src/hms_scan.sv
// Display multiplexer decode: digit select, tens/units split, segments, dots, blanking.
// Depends on hms_pkg.
module hms_scan (
	input  hms_pkg::clk_state_t state,
	output logic [7:0]          segs,
	output logic [5:0]          enable,
	output logic [2:0]          scan_next
);
	import hms_pkg::*;

	logic [2:0]  idx;
	logic [1:0]  pair;
	logic [5:0]  val;
	logic [13:0] prod;
	logic [3:0]  tens;
	logic [5:0]  units;
	logic [3:0]  digit;
	logic        set_active;

	assign idx        = (state.scan > LAST_DIGIT) ? 3'd0 : state.scan;
	assign pair       = idx[2:1];
	assign set_active = (state.mode != MODE_RUN);

	always_comb begin
		unique case (pair)
			2'd0:    val = state.sec;
			2'd1:    val = state.min;
			default: val = {1'b0, state.hour};
		endcase
	end

	// divide by ten via reciprocal, exact for six-bit values
	assign prod  = {8'd0, val} * {6'd0, TENS_RECIP};
	assign tens  = {1'b0, prod[TENS_SHIFT +: 3]};
	assign units = val - 6'({tens, 3'b000} + {tens, 1'b0});
	assign digit = idx[0] ? tens : units[3:0];

	always_comb begin
		segs = seg_code(digit);
		if (!idx[0] && (idx != 3'd0) && (state.blink || set_active))
			segs[7] = 1'b0;
		enable = '0;
		if (!(state.blink && set_active && (pair == mode_code(state.mode))))
			enable = 6'd1 << idx;
	end

	assign scan_next = (idx >= LAST_DIGIT) ? 3'd0 : idx + 3'd1;

endmodule

### src/hms_core.sv
// Clock state registers and their next-state logic: time counting, set-button hold,
// set mode stepping and adjustment, blink phase and scan position. Depends on hms_pkg.
module hms_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  hms_pkg::item_t      item,
	input  logic [3:0]          hold_limit,
	input  logic [2:0]          scan_next,
	output hms_pkg::clk_state_t cur,
	output hms_pkg::clk_state_t nxt,
	output logic                restart
);
	import hms_pkg::*;

	clk_state_t state_q;
	logic [3:0] hold_q;
	logic [3:0] hold_d;
	logic [5:0] sec_inc;
	logic [5:0] min_inc;
	logic [4:0] hour_inc;
	logic [4:0] ticks;

	assign cur      = state_q;
	assign sec_inc  = state_q.sec + 6'd1;
	assign min_inc  = state_q.min + 6'd1;
	assign hour_inc = state_q.hour + 5'd1;
	assign ticks    = {1'b0, hold_q} + 5'd1;

	always_comb begin
		nxt     = state_q;
		hold_d  = hold_q;
		restart = 1'b0;
		unique case (item.kind)
			KIND_SEC_TICK: begin
				if (state_q.mode == MODE_RUN) begin
					if (state_q.sec >= SEC_WRAP - 6'd1) begin
						nxt.sec = '0;
						if (state_q.min >= MIN_WRAP - 6'd1) begin
							nxt.min  = '0;
							nxt.hour = (state_q.hour >= HOUR_WRAP - 5'd1) ? '0 : hour_inc;
						end else begin
							nxt.min = min_inc;
						end
					end else begin
						nxt.sec = sec_inc;
					end
					if (item.set_button) begin
						if (ticks >= {1'b0, hold_limit}) begin
							nxt.mode = MODE_SET_HOUR;
							nxt.sec  = '0;
							hold_d   = '0;
						end else begin
							hold_d = ticks[3:0];
						end
					end else begin
						hold_d = '0;
					end
				end
			end
			KIND_BLINK_TICK: nxt.blink = ~state_q.blink;
			KIND_BUTTON: begin
				if (state_q.mode != MODE_RUN) begin
					priority if (item.set_button) begin
						unique case (state_q.mode)
							MODE_SET_HOUR: nxt.mode = MODE_SET_MIN;
							MODE_SET_MIN: begin
								nxt.mode = MODE_RUN;
								restart  = 1'b1;
							end
							default: nxt.mode = state_q.mode;
						endcase
					end else if (item.up_button) begin
						if (state_q.mode == MODE_SET_HOUR)
							nxt.hour = (state_q.hour >= HOUR_MAX) ? '0 : hour_inc;
						else if (state_q.mode == MODE_SET_MIN)
							nxt.min = (state_q.min >= MIN_MAX) ? '0 : min_inc;
					end else if (item.down_button) begin
						if (state_q.mode == MODE_SET_HOUR)
							nxt.hour = (state_q.hour == '0 || state_q.hour > HOUR_MAX) ?
								HOUR_MAX : state_q.hour - 5'd1;
						else if (state_q.mode == MODE_SET_MIN)
							nxt.min = (state_q.min == '0 || state_q.min > MIN_MAX) ?
								MIN_MAX : state_q.min - 6'd1;
					end else begin
						nxt = state_q;
					end
				end
			end
			KIND_SCAN: nxt.scan = scan_next;
			default: nxt = state_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.hour  <= HOUR_RESET;
			state_q.min   <= '0;
			state_q.sec   <= '0;
			state_q.mode  <= MODE_RUN;
			state_q.blink <= 1'b0;
			state_q.scan  <= '0;
			hold_q        <= '0;
		end else if (fire) begin
			state_q <= nxt;
			hold_q  <= hold_d;
		end
	end

`ifndef SYNTHESIS
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hour < HOUR_WRAP) else $error("hour count out of range");
	a_min_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.min < MIN_WRAP && state_q.sec < SEC_WRAP) else $error("min/sec out of range");
	a_restart_run: assert property (@(posedge clk) disable iff (!arst_n)
		fire && restart |=> state_q.mode == MODE_RUN) else $error("restart without run");
	a_hold_clear_set: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_SET_HOUR && $past(state_q.mode) == MODE_RUN |-> hold_q == '0)
		else $error("hold count not cleared on entering set mode");
`endif

endmodule

### src/hms_clock_with_set_mode_unit.sv
// Top level of the hh:mm:ss clock with set mode and six-digit display scan.
// Depends on hms_pkg, hms_scan and hms_core.
//
// Input channel: in_valid/in_stall with kind, set_button, up_button, down_button.
// Output channel: out_valid/out_stall carrying one result per input transaction:
// segments and digit_enable for scan steps (blank otherwise), the time fields,
// mode, restart_second and blink_phase after the update.
// Configuration: cfg_wr_en/cfg_wr_data write hold_limit (reset value 3).
// Path: the input register, then the state update, then the result register.
// Throughput: one transaction per cycle while out_stall is low; the state update is
// counter logic between the input register and the result register.
// Reset: time is 12:00:00, run mode, blink phase and scan position zero, both
// registers empty.
// Stall: the result register holds while out_stall is high; the input register
// keeps taking one more transaction, then in_stall rises until the result moves.
module hms_clock_with_set_mode_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic       set_button,
	input  logic       up_button,
	input  logic       down_button,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] segments,
	output logic [5:0] digit_enable,
	output logic [4:0] hours,
	output logic [5:0] minutes,
	output logic [5:0] seconds,
	output logic [1:0] mode,
	output logic       restart_second,
	output logic       blink_phase
);
	import hms_pkg::*;

	logic [3:0] hold_lim_q;
	logic       valid_s1;
	item_t      item_s1;
	logic       out_free;
	logic       advance;
	clk_state_t cur;
	clk_state_t nxt;
	logic       restart;
	logic [7:0] scan_segs;
	logic [5:0] scan_en;
	logic [2:0] scan_next;

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_lim_q <= HOLD_RESET;
		end else if (cfg_wr_en) begin
			hold_lim_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= '{kind: kind_t'(kind), set_button: set_button,
				up_button: up_button, down_button: down_button};
	end

	hms_scan u_scan (
		.state     (cur),
		.segs      (scan_segs),
		.enable    (scan_en),
		.scan_next (scan_next)
	);

	hms_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.item       (item_s1),
		.hold_limit (hold_lim_q),
		.scan_next  (scan_next),
		.cur        (cur),
		.nxt        (nxt),
		.restart    (restart)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_free)
			out_valid <= advance;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (item_s1.kind == KIND_SCAN) begin
				segments     <= scan_segs;
				digit_enable <= scan_en;
			end else begin
				segments     <= SEG_BLANK;
				digit_enable <= '0;
			end
			hours          <= nxt.hour;
			minutes        <= nxt.min;
			seconds        <= nxt.sec;
			mode           <= mode_code(nxt.mode);
			restart_second <= restart;
			blink_phase    <= nxt.blink;
		end
	end

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall) else $error("spurious input stall");
	a_restart_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && restart_second |-> mode == MODE_CODE_RUN) else $error("restart outside run");
	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(digit_enable)) else $error("digit enable not one-hot");
	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> hold_lim_q == $past(cfg_wr_data))
		else $error("hold limit write lost");
`endif

endmodule

### test/hms_clock_checker.sv
`timescale 1ns / 1ps
// Scoreboard for hms_clock_with_set_mode_unit. It follows configuration writes and both channels,
// predicts each result and compares it field by field. It depends on hms_pkg.
module hms_clock_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] kind,
	input  logic       set_button,
	input  logic       up_button,
	input  logic       down_button,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] segments,
	input  logic [5:0] digit_enable,
	input  logic [4:0] hours,
	input  logic [5:0] minutes,
	input  logic [5:0] seconds,
	input  logic [1:0] mode,
	input  logic       restart_second,
	input  logic       blink_phase,
	output int         fail_count,
	output int         pending,
	output logic [4:0] now_hour,
	output logic [5:0] now_min,
	output logic [1:0] now_mode
);
	import hms_pkg::*;

	typedef struct packed {
		logic [7:0] segs;
		logic [5:0] en;
		logic [4:0] hour;
		logic [5:0] min;
		logic [5:0] sec;
		logic [1:0] mode;
		logic       restart;
		logic       blink;
	} face_t;

	localparam logic [9:0][7:0] DIGIT_SEGS = {8'h90, 8'h80, 8'hf8, 8'h82, 8'h92,
		8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0};

	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [4:0] hour_q;
	logic [1:0] mode_q;
	logic [3:0] held_q;
	logic       blink_q;
	logic [2:0] digit_q;
	logic [3:0] hold_limit_q;
	face_t      expected_faces[$];
	face_t      want;

	assign now_hour = hour_q;
	assign now_min  = min_q;
	assign now_mode = mode_q;

	function automatic face_t next_face(input kind_t k, input logic sb, input logic ub,
			input logic db);
		face_t      f;
		logic [4:0] t;
		logic [2:0] i;
		logic [1:0] pair;
		logic [5:0] v;
		logic [3:0] d;
		f.segs    = SEG_BLANK;
		f.en      = '0;
		f.restart = 1'b0;
		case (k)
			KIND_SEC_TICK: begin
				if (mode_q == MODE_CODE_RUN) begin
					sec_q = sec_q + 6'd1;
					if (sec_q >= SEC_WRAP) begin
						sec_q = '0;
						min_q = min_q + 6'd1;
						if (min_q >= MIN_WRAP) begin
							min_q  = '0;
							hour_q = hour_q + 5'd1;
							if (hour_q >= HOUR_WRAP)
								hour_q = '0;
						end
					end
					if (sb) begin
						t = {1'b0, held_q} + 5'd1;
						if (t >= {1'b0, hold_limit_q}) begin
							mode_q = MODE_CODE_HOUR;
							sec_q  = '0;
							held_q = '0;
						end else
							held_q = t[3:0];
					end else
						held_q = '0;
				end
			end
			KIND_BLINK_TICK: blink_q = ~blink_q;
			KIND_BUTTON: begin
				if (mode_q != MODE_CODE_RUN) begin
					if (sb) begin
						mode_q    = mode_q - 2'd1;
						f.restart = (mode_q == MODE_CODE_RUN);
					end else if (ub) begin
						if (mode_q == MODE_CODE_HOUR)
							hour_q = (hour_q >= HOUR_MAX) ? 5'd0 : hour_q + 5'd1;
						else if (mode_q == MODE_CODE_MIN)
							min_q = (min_q >= MIN_MAX) ? 6'd0 : min_q + 6'd1;
					end else if (db) begin
						if (mode_q == MODE_CODE_HOUR)
							hour_q = (hour_q == 0 || hour_q > HOUR_MAX) ? HOUR_MAX : hour_q - 5'd1;
						else if (mode_q == MODE_CODE_MIN)
							min_q = (min_q == 0 || min_q > MIN_MAX) ? MIN_MAX : min_q - 6'd1;
					end
				end
			end
			default: begin
				i    = (digit_q > LAST_DIGIT) ? 3'd0 : digit_q;
				pair = i[2:1];
				v    = (pair == 2'd0) ? sec_q : (pair == 2'd1) ? min_q : {1'b0, hour_q};
				d    = i[0] ? 4'((v / 6'd10) % 6'd10) : 4'(v % 6'd10);
				f.segs = DIGIT_SEGS[d];
				if (!i[0] && i != 0 && (blink_q || mode_q != MODE_CODE_RUN))
					f.segs[7] = 1'b0;
				if (!(blink_q && mode_q != MODE_CODE_RUN && pair == mode_q))
					f.en = 6'b1 << i;
				digit_q = (i >= LAST_DIGIT) ? 3'd0 : i + 3'd1;
			end
		endcase
		f.hour  = hour_q;
		f.min   = min_q;
		f.sec   = sec_q;
		f.mode  = mode_q;
		f.blink = blink_q;
		return f;
	endfunction

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			fail_count++;
			if (fail_count <= 50)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
					exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q        = '0;
			min_q        = '0;
			hour_q       = HOUR_RESET;
			mode_q       = MODE_CODE_RUN;
			held_q       = '0;
			blink_q      = 1'b0;
			digit_q      = '0;
			hold_limit_q = HOLD_RESET;
			expected_faces.delete();
			fail_count   = 0;
			pending      = 0;
		end else begin
			// result side first, so an unexpected result is never masked
			if (out_valid && !out_stall) begin
				if (expected_faces.size() == 0) begin
					fail_count++;
					if (fail_count <= 50)
						$display("%0t: result with no transaction pending, expected none, actual %h",
							$time, {segments, digit_enable, hours, minutes, seconds, mode,
							restart_second, blink_phase});
				end else begin
					want = expected_faces.pop_front();
					check_field("segments", want.segs, segments);
					check_field("digit_enable", want.en, digit_enable);
					check_field("hours", want.hour, hours);
					check_field("minutes", want.min, minutes);
					check_field("seconds", want.sec, seconds);
					check_field("mode", want.mode, mode);
					check_field("restart_second", want.restart, restart_second);
					check_field("blink_phase", want.blink, blink_phase);
				end
			end
			if (cfg_wr_en)
				hold_limit_q = cfg_wr_data;
			if (in_valid && !in_stall)
				expected_faces.push_back(next_face(kind_t'(kind), set_button, up_button,
					down_button));
			pending = expected_faces.size();
		end
	end

endmodule

### test/tb_hms_clock_with_set_mode_unit.sv
`timescale 1ns / 1ps
// Top of the regression for hms_clock_with_set_mode_unit: clock, reset, stimulus and the verdict.
// It depends on hms_pkg, the block and hms_clock_checker.
module tb_hms_clock_with_set_mode_unit;
	import hms_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 250;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] kind;
	logic       set_button;
	logic       up_button;
	logic       down_button;
	logic       cfg_wr_en;
	logic [3:0] cfg_wr_data;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] segments;
	logic [5:0] digit_enable;
	logic [4:0] hours;
	logic [5:0] minutes;
	logic [5:0] seconds;
	logic [1:0] mode;
	logic       restart_second;
	logic       blink_phase;

	int         fail_count;
	int         pending;
	logic [4:0] now_hour;
	logic [5:0] now_min;
	logic [1:0] now_mode;
	int         in_idle_pct;
	int         out_idle_pct;
	int         sent;
	int         cycles;

	hms_clock_with_set_mode_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .set_button(set_button), .up_button(up_button), .down_button(down_button),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.segments(segments), .digit_enable(digit_enable),
		.hours(hours), .minutes(minutes), .seconds(seconds), .mode(mode),
		.restart_second(restart_second), .blink_phase(blink_phase)
	);

	hms_clock_checker clock_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .set_button(set_button), .up_button(up_button), .down_button(down_button),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.segments(segments), .digit_enable(digit_enable),
		.hours(hours), .minutes(minutes), .seconds(seconds), .mode(mode),
		.restart_second(restart_second), .blink_phase(blink_phase),
		.fail_count(fail_count), .pending(pending),
		.now_hour(now_hour), .now_min(now_min), .now_mode(now_mode)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("hms_clock_with_set_mode_unit regression: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < out_idle_pct);
	end

	function automatic logic coin();
		return 1'($urandom_range(1));
	endfunction

	// one transaction, with random sender gaps ahead of it
	task automatic send(input kind_t k, input logic sb, input logic ub, input logic db);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid    <= 1'b0;
			kind        <= 2'($urandom_range(3));
			set_button  <= coin();
			up_button   <= coin();
			down_button <= coin();
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		set_button  <= sb;
		up_button   <= ub;
		down_button <= db;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_noise();
		send(kind_t'($urandom_range(3)), coin(), coin(), coin());
	endtask

	// scans and blink ticks that leave time and hold count alone
	task automatic chatter();
		send(($urandom_range(3) == 0) ? KIND_BLINK_TICK : KIND_SCAN, coin(), coin(), coin());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic [3:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// adjust the field being set; to_limit walks it up to its top value
	task automatic tweak_field(input bit to_limit);
		int n;
		n = 0;
		if (to_limit) begin
			while (n < 70 && ((now_mode == MODE_CODE_HOUR) ? (now_hour != HOUR_MAX) :
					(now_min != MIN_MAX))) begin
				if ($urandom_range(4) == 0)
					chatter();
				send(KIND_BUTTON, 1'b0, 1'b1, coin());
				n++;
			end
		end else begin
			repeat ($urandom_range(8)) begin
				case ($urandom_range(5))
					0:       chatter();
					1:       send(KIND_SEC_TICK, coin(), coin(), coin());
					default: send(KIND_BUTTON, 1'b0, coin(), coin());
				endcase
			end
		end
	endtask

	// hold set to enter, adjust hours and minutes, return to run, then let time go on
	task automatic set_session();
		bit to_limit;
		int guard;
		to_limit = ($urandom_range(2) == 0);
		guard    = 0;
		while (now_mode == MODE_CODE_RUN && guard < 100) begin
			if ($urandom_range(19) == 0)
				send(KIND_SEC_TICK, 1'b0, coin(), coin());
			else if ($urandom_range(3) == 0)
				chatter();
			else
				send(KIND_SEC_TICK, 1'b1, coin(), coin());
			guard++;
		end
		tweak_field(to_limit);
		send(KIND_BUTTON, 1'b1, coin(), coin());
		tweak_field(to_limit);
		send(KIND_BUTTON, 1'b1, coin(), coin());
		repeat (to_limit ? 61 : $urandom_range(3, 12)) begin
			if ($urandom_range(3) == 0)
				chatter();
			send(KIND_SEC_TICK, ($urandom_range(15) == 0), coin(), coin());
		end
	endtask

	initial begin
		int target;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = KIND_SEC_TICK;
		set_button   = 1'b0;
		up_button    = 1'b0;
		down_button  = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		out_stall    = 1'b0;
		in_idle_pct  = 0;
		out_idle_pct = 0;
		sent         = 0;
		cycles       = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: display walk, dots, run-mode buttons, hold and its break,
		// frozen time, button priorities, field wrap, blanking, restart
		repeat (6) send(KIND_SCAN, 1'b0, 1'b0, 1'b0);
		send(KIND_BLINK_TICK, 1'b0, 1'b0, 1'b0);
		repeat (3) send(KIND_SCAN, 1'b0, 1'b0, 1'b0);
		send(KIND_BUTTON, 1'b0, 1'b1, 1'b0);
		send(KIND_SEC_TICK, 1'b1, 1'b0, 1'b0);
		send(KIND_SEC_TICK, 1'b0, 1'b0, 1'b0);
		repeat (3) send(KIND_SEC_TICK, 1'b1, 1'b0, 1'b0);
		send(KIND_SEC_TICK, 1'b1, 1'b0, 1'b0);
		send(KIND_BUTTON, 1'b0, 1'b0, 1'b0);
		send(KIND_BUTTON, 1'b0, 1'b1, 1'b1);
		send(KIND_BUTTON, 1'b0, 1'b0, 1'b1);
		send(KIND_SCAN, 1'b0, 1'b0, 1'b0);
		send(KIND_SCAN, 1'b0, 1'b0, 1'b0);
		send(KIND_BUTTON, 1'b1, 1'b1, 1'b1);
		send(KIND_BUTTON, 1'b0, 1'b0, 1'b1);
		send(KIND_BUTTON, 1'b0, 1'b1, 1'b0);
		send(KIND_BUTTON, 1'b1, 1'b0, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       write_limit(4'd15);
				1:       write_limit(4'd0);
				2:       write_limit(4'd1);
				4:       write_limit(HOLD_RESET);
				default: write_limit(4'($urandom_range(2, 14)));
			endcase
			case (ph / 2)
				0: begin
					in_idle_pct  = 21;
					out_idle_pct = 86;
				end
				1: begin
					in_idle_pct  = 86;
					out_idle_pct = 21;
				end
				default: begin
					in_idle_pct  = 0;
					out_idle_pct = 0;
				end
			endcase
			target = sent + PHASE_ITEMS;
			while (sent < target) begin
				if ($urandom_range(99) < 30)
					set_session();
				else
					send_noise();
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("hms_clock_with_set_mode_unit regression: pass");
		else
			$display("hms_clock_with_set_mode_unit regression: fail");
		$finish;
	end

endmodule

### sim.f
src/hms_pkg.sv
src/hms_scan.sv
src/hms_core.sv
src/hms_clock_with_set_mode_unit.sv
test/hms_clock_checker.sv
test/tb_hms_clock_with_set_mode_unit.sv
